// ----- design/sbo_pkg.sv -----
// shared widths, types and axis codes for the segment / box overlap test
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps
package sbo_pkg;

   // coordinate width, signed q15.8 at the default of 24
   localparam int COORD_WIDTH = 24;
   localparam int NUM_AXES    = 3;
   localparam int NUM_FIELDS  = 4 * NUM_AXES;

   // payload widths, padded to whole bytes
   localparam int REQ_BITS        = NUM_FIELDS * COORD_WIDTH;
   localparam int REQ_DATA_WIDTH  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH  = 8;

   // field slots in the request beat, lowest first
   localparam int SLOT_MIN   = 0;
   localparam int SLOT_MAX   = NUM_AXES;
   localparam int SLOT_START = 2 * NUM_AXES;
   localparam int SLOT_END   = 3 * NUM_AXES;

   // axis codes
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   // arithmetic widths
   localparam int SPAN_WIDTH  = COORD_WIDTH + 1;        // s = end - start, b = max - min
   localparam int DIFF_WIDTH  = COORD_WIDTH + 2;        // d = doubled centre difference
   localparam int FACE_WIDTH  = COORD_WIDTH + 3;        // face compare
   localparam int PROD_WIDTH  = SPAN_WIDTH + DIFF_WIDTH; // one cross product term
   localparam int CROSS_WIDTH = PROD_WIDTH + 2;         // sums and magnitudes of terms

   // pipeline depth, input beat to output register
   localparam int NUM_STAGES = 6;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [SPAN_WIDTH-1:0]  span_type;
   typedef logic        [SPAN_WIDTH-1:0]  span_mag_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [FACE_WIDTH-1:0]  face_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [CROSS_WIDTH-1:0] cross_type;

endpackage

// ----- design/segment_box_overlap_test_top.sv -----
// segment versus axis-aligned box overlap, separating-axis test, six-stage pipeline
// depends on sbo_pkg
`timescale 1ns / 1ps
//
//   channel | dir | payload (low bit first)                              | beat when
//   --------+-----+------------------------------------------------------+-------------------------
//   req     | in  | box_min xyz, box_max xyz, start xyz, end xyz         | req_tvalid & req_tready
//   rsp     | out | overlaps, zero pad to 8 bits                         | rsp_tvalid & rsp_tready
//
// one beat in, one beat out, in order; a new beat can enter every cycle unless the pipe is full and rsp is stalled
// each beat passes through span/diff, face test, cross multiplies, cross sums,
// magnitude, compare into the output register
// every stage has its own valid bit and holds only when the stage after it is full
// and stalled, so the pipe keeps filling while a finished result waits in rsp
// reset is synchronous, active high, and clears the valid bits only
module segment_box_overlap_test_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
   // start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [sbo_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // overlaps, then zeros
   output logic [sbo_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int W  = sbo_pkg::COORD_WIDTH;
   localparam int NA = sbo_pkg::NUM_AXES;
   localparam int NS = sbo_pkg::NUM_STAGES;

   // ---------------------------------------------------------------- flow control
   logic [NS:1] vld_ff;
   logic [NS:1] vld_in;
   logic [NS:1] rdy;
   logic [NS:1] ld;

   always_comb begin
      rdy[NS] = !vld_ff[NS] || rsp_tready;
      for (int k = NS - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[1] = req_tvalid;
      for (int k = 2; k <= NS; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
      ld = rdy & vld_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_tready = rdy[1];

   // ---------------------------------------------------------------- stage 1
   // per axis: s = end - start, b = max - min, d = (start + end) - (min + max)
   sbo_pkg::span_type s1_ff [NA];
   sbo_pkg::span_type b1_ff [NA];
   sbo_pkg::diff_type d1_ff [NA];
   sbo_pkg::span_type s1_in [NA];
   sbo_pkg::span_type b1_in [NA];
   sbo_pkg::diff_type d1_in [NA];

   always_comb begin
      sbo_pkg::coord_type lo, hi, p0, p1;
      for (int a = 0; a < NA; a++) begin
         lo = req_tdata[(sbo_pkg::SLOT_MIN   + a) * W +: W];
         hi = req_tdata[(sbo_pkg::SLOT_MAX   + a) * W +: W];
         p0 = req_tdata[(sbo_pkg::SLOT_START + a) * W +: W];
         p1 = req_tdata[(sbo_pkg::SLOT_END   + a) * W +: W];
         s1_in[a] = sbo_pkg::SPAN_WIDTH'(p1) - sbo_pkg::SPAN_WIDTH'(p0);
         b1_in[a] = sbo_pkg::SPAN_WIDTH'(hi) - sbo_pkg::SPAN_WIDTH'(lo);
         d1_in[a] = (sbo_pkg::DIFF_WIDTH'(p0) + sbo_pkg::DIFF_WIDTH'(p1))
                  - (sbo_pkg::DIFF_WIDTH'(lo) + sbo_pkg::DIFF_WIDTH'(hi));
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s1_ff <= s1_in;
         b1_ff <= b1_in;
         d1_ff <= d1_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // face axes: |d| <= |s| + b on each axis, touching passes
   sbo_pkg::span_type     s2_ff   [NA];
   sbo_pkg::span_type     b2_ff   [NA];
   sbo_pkg::diff_type     d2_ff   [NA];
   sbo_pkg::span_mag_type sm2_ff  [NA];
   sbo_pkg::span_mag_type sm2_in  [NA];
   logic                  face2_ff;
   logic                  face2_in;

   always_comb begin
      sbo_pkg::face_type ad, lim;
      face2_in = 1'b1;
      for (int a = 0; a < NA; a++) begin
         sm2_in[a] = s1_ff[a][sbo_pkg::SPAN_WIDTH-1] ? sbo_pkg::span_mag_type'(-s1_ff[a])
                                                     : sbo_pkg::span_mag_type'(s1_ff[a]);
         ad  = d1_ff[a][sbo_pkg::DIFF_WIDTH-1] ? -sbo_pkg::FACE_WIDTH'(d1_ff[a])
                                               :  sbo_pkg::FACE_WIDTH'(d1_ff[a]);
         lim = sbo_pkg::FACE_WIDTH'({1'b0, sm2_in[a]}) + sbo_pkg::FACE_WIDTH'(b1_ff[a]);
         if (ad > lim) begin
            face2_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s2_ff    <= s1_ff;
         b2_ff    <= b1_ff;
         d2_ff    <= d1_ff;
         sm2_ff   <= sm2_in;
         face2_ff <= face2_in;
      end
   end

   // ---------------------------------------------------------------- stages 3 to 6
   // cross axes use axis pairs (y,z), (x,y), (z,x):
   //   |s1*d2 - d1*s2| <= |s1|*b2 + b1*|s2|
   logic face3_ff, face4_ff, face5_ff;
   logic [NA-1:0] cross_ok;

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         face3_ff <= face2_ff;
      end
      if (ld[4]) begin
         face4_ff <= face3_ff;
      end
      if (ld[5]) begin
         face5_ff <= face4_ff;
      end
   end

   for (genvar c = 0; c < NA; c++) begin : g_cross
      localparam int I1 = (c == 0) ? sbo_pkg::AXIS_Y :
                          (c == 1) ? sbo_pkg::AXIS_X : sbo_pkg::AXIS_Z;
      localparam int I2 = (c == 0) ? sbo_pkg::AXIS_Z :
                          (c == 1) ? sbo_pkg::AXIS_Y : sbo_pkg::AXIS_X;

      sbo_pkg::prod_type  sd_ff, ds_ff, mb_ff, bm_ff;
      sbo_pkg::diff_type  sm1, sm2;
      sbo_pkg::cross_type lhs_ff, rhs_ff, mag_ff, rhs5_ff;
      sbo_pkg::cross_type lhs_in, rhs_in, mag_in;

      // magnitudes as signed operands, one bit wider
      assign sm1 = sbo_pkg::diff_type'({1'b0, sm2_ff[I1]});
      assign sm2 = sbo_pkg::diff_type'({1'b0, sm2_ff[I2]});

      // stage 3: the four products
      always_ff @(posedge clock) begin
         if (ld[3]) begin
            sd_ff <= sbo_pkg::PROD_WIDTH'(s2_ff[I1]) * sbo_pkg::PROD_WIDTH'(d2_ff[I2]);
            ds_ff <= sbo_pkg::PROD_WIDTH'(d2_ff[I1]) * sbo_pkg::PROD_WIDTH'(s2_ff[I2]);
            mb_ff <= sbo_pkg::PROD_WIDTH'(sm1) * sbo_pkg::PROD_WIDTH'(b2_ff[I2]);
            bm_ff <= sbo_pkg::PROD_WIDTH'(b2_ff[I1]) * sbo_pkg::PROD_WIDTH'(sm2);
         end
      end

      // stage 4: difference and bound
      assign lhs_in = sbo_pkg::CROSS_WIDTH'(sd_ff) - sbo_pkg::CROSS_WIDTH'(ds_ff);
      assign rhs_in = sbo_pkg::CROSS_WIDTH'(mb_ff) + sbo_pkg::CROSS_WIDTH'(bm_ff);

      always_ff @(posedge clock) begin
         if (ld[4]) begin
            lhs_ff <= lhs_in;
            rhs_ff <= rhs_in;
         end
      end

      // stage 5: magnitude of the difference
      assign mag_in = lhs_ff[sbo_pkg::CROSS_WIDTH-1] ? -lhs_ff : lhs_ff;

      always_ff @(posedge clock) begin
         if (ld[5]) begin
            mag_ff  <= mag_in;
            rhs5_ff <= rhs_ff;
         end
      end

      // bound may be negative for an inverted box
      assign cross_ok[c] = (mag_ff <= rhs5_ff);
   end

   // stage 6: output register
   logic overlaps_ff;
   logic overlaps_in;

   assign overlaps_in = face5_ff && (&cross_ok);

   always_ff @(posedge clock) begin
      if (ld[6]) begin
         overlaps_ff <= overlaps_in;
      end
   end

   assign rsp_tvalid = vld_ff[NS];
   assign rsp_tdata  = sbo_pkg::RSP_DATA_WIDTH'(overlaps_ff);

endmodule

// ----- design/sbo_checker.sv -----
// port-level checks for segment_box_overlap_test_top, bound to it below
// depends on sbo_pkg and the top level
`timescale 1ns / 1ps
module sbo_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [sbo_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [sbo_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // a held result beat keeps its data
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // reset empties the pipe
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // the input side only backs up when a result sits unclaimed
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled with output free");

   // with the output open, an accepted beat reaches rsp_tvalid once it has passed through every stage
   a_latency : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing after pipeline latency");

   // pad bits of the result stay zero
   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[sbo_pkg::RSP_DATA_WIDTH-1:1] == '0)
      else $error("rsp pad bits set");

endmodule

bind segment_box_overlap_test_top sbo_checker u_sbo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
